// File: src/ttf_pkg.sv
// Shared types and constants for the triangle tangent frame unit.
`default_nettype none
package ttf_pkg;
  localparam int InW      = 32;
  localparam int DiffW    = 33;
  localparam int ProdW    = 66;
  localparam int AccW     = 68;
  localparam int NormBits = 31;
  localparam int SsW      = 64;
  localparam int LenW     = 33;
  localparam int StepW    = 4;
  localparam logic [StepW-1:0] MulLast = 4'd13;
  localparam logic [StepW-1:0] SqLast  = 4'd2;

  localparam logic CfgIdxTangent   = 1'b0;
  localparam logic CfgIdxBitangent = 1'b1;

  typedef enum logic [1:0] {
    PH_V0 = 2'd0,
    PH_V1 = 2'd1,
    PH_V2 = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_VSEL,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIVLD,
    ST_DIV,
    ST_DIVST,
    ST_VNEXT,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// File: src/ttf_if.sv
// Input vertex and output frame channel interfaces.
`default_nettype none
interface ttf_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [ttf_pkg::InW-1:0]   pos_x;
  logic signed [ttf_pkg::InW-1:0]   pos_y;
  logic signed [ttf_pkg::InW-1:0]   pos_z;
  logic signed [ttf_pkg::InW-1:0]   tex_u;
  logic signed [ttf_pkg::InW-1:0]   tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttf_out_if #(parameter int OutW = 18);
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] tangent_x;
  logic signed [OutW-1:0] tangent_y;
  logic signed [OutW-1:0] tangent_z;
  logic signed [OutW-1:0] bitangent_x;
  logic signed [OutW-1:0] bitangent_y;
  logic signed [OutW-1:0] bitangent_z;
  logic                   tangent_valid;
  logic                   bitangent_valid;
  logic                   degenerate;
  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, tangent_valid, bitangent_valid, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, tangent_valid, bitangent_valid, degenerate, output ready);
endinterface
`default_nettype wire

// File: src/triangle_tangent_frame_unit.sv
// Triangle tangent frame unit: per-triangle unit tangent and bitangent from UVs.
// Vertices 0 and 1 are only captured. Vertex 2 starts the computation: the one shared
// 33x33 multiplier forms the determinant and products, then each enabled vector goes
// through the one-bit normalize shifter, the bit-pair square root loop and the
// restoring divider.
// Reset: asynchronous active low; phase to vertex 0, both enables set, no beat pending.
`default_nettype none
module triangle_tangent_frame_unit #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  ttf_in_if.sink            in_i,
  ttf_out_if.source         out_o,
  input  wire               cfg_we_i,
  input  wire               cfg_idx_i,
  input  wire               cfg_data_i
);
  localparam int OutW = OUT_FRAC_BITS + 2;
  localparam int NumW = ttf_pkg::NormBits + 1 + OUT_FRAC_BITS;
  localparam int CntW = $clog2(NumW + 1);
  localparam int AccW = ttf_pkg::AccW;

  ttf_pkg::state_e state_q, state_d;
  ttf_pkg::phase_e phase_q;
  logic cfg_t_q, cfg_b_q;

  logic signed [ttf_pkg::InW-1:0] hp0_q [3];
  logic signed [ttf_pkg::InW-1:0] hp1_q [3];
  logic signed [ttf_pkg::InW-1:0] p2_q  [3];
  logic signed [ttf_pkg::InW-1:0] ht0_q [2];
  logic signed [ttf_pkg::InW-1:0] ht1_q [2];
  logic signed [ttf_pkg::InW-1:0] t2_q  [2];

  logic [ttf_pkg::StepW-1:0] step_q;
  logic signed [AccW-1:0] acc_q, det_q;
  logic signed [AccW-1:0] tn_q [3];
  logic signed [AccW-1:0] bn_q [3];
  logic                   vec_q;
  logic [AccW-1:0]        m_q [3];
  logic                   neg_q [3];
  logic [ttf_pkg::SsW-1:0] ss_q, sx_q, sr_q, sb_q;
  logic [1:0]             comp_q;
  logic [NumW-1:0]        num_q, quo_q;
  logic [ttf_pkg::LenW-1:0] rem_q;
  logic [CntW-1:0]        cnt_q;
  logic signed [OutW-1:0] res_q [2][3];
  logic                   degen_q;

  logic                   ov_q, otv_q, obv_q, odg_q;
  logic signed [OutW-1:0] ores_q [2][3];

  logic signed [ttf_pkg::DiffW-1:0] d1 [3];
  logic signed [ttf_pkg::DiffW-1:0] d2 [3];
  logic signed [ttf_pkg::DiffW-1:0] du1, dv1, du2, dv2, mul_a, mul_b;
  logic signed [ttf_pkg::ProdW-1:0] mul_p;
  logic signed [AccW-1:0]           mul_x, mul_r;
  logic                             in_acc, out_load, vec_en, flip;
  logic [AccW-1:0]                  m_or;
  logic [ttf_pkg::SsW-1:0]          sq_t;
  logic [ttf_pkg::LenW:0]           div_t;
  logic [OutW-1:0]                  qv;

  for (genvar k = 0; k < 3; k++) begin : g_diff
    assign d1[k] = ttf_pkg::DiffW'(hp1_q[k]) - ttf_pkg::DiffW'(hp0_q[k]);
    assign d2[k] = ttf_pkg::DiffW'(p2_q[k]) - ttf_pkg::DiffW'(hp0_q[k]);
  end
  assign du1 = ttf_pkg::DiffW'(ht1_q[0]) - ttf_pkg::DiffW'(ht0_q[0]);
  assign dv1 = ttf_pkg::DiffW'(ht1_q[1]) - ttf_pkg::DiffW'(ht0_q[1]);
  assign du2 = ttf_pkg::DiffW'(t2_q[0]) - ttf_pkg::DiffW'(ht0_q[0]);
  assign dv2 = ttf_pkg::DiffW'(t2_q[1]) - ttf_pkg::DiffW'(ht0_q[1]);

  always_comb begin
    mul_a = du1;
    mul_b = dv2;
    if (state_q == ttf_pkg::ST_SQ) begin
      mul_a = {2'b00, m_q[step_q[1:0]][ttf_pkg::NormBits-1:0]};
      mul_b = mul_a;
    end else begin
      unique case (step_q)
        4'd0:    begin mul_a = du1; mul_b = dv2;   end
        4'd1:    begin mul_a = du2; mul_b = dv1;   end
        4'd2:    begin mul_a = dv2; mul_b = d1[0]; end
        4'd3:    begin mul_a = dv1; mul_b = d2[0]; end
        4'd4:    begin mul_a = dv2; mul_b = d1[1]; end
        4'd5:    begin mul_a = dv1; mul_b = d2[1]; end
        4'd6:    begin mul_a = dv2; mul_b = d1[2]; end
        4'd7:    begin mul_a = dv1; mul_b = d2[2]; end
        4'd8:    begin mul_a = du1; mul_b = d2[0]; end
        4'd9:    begin mul_a = du2; mul_b = d1[0]; end
        4'd10:   begin mul_a = du1; mul_b = d2[1]; end
        4'd11:   begin mul_a = du2; mul_b = d1[1]; end
        4'd12:   begin mul_a = du1; mul_b = d2[2]; end
        4'd13:   begin mul_a = du2; mul_b = d1[2]; end
        default: begin mul_a = du1; mul_b = dv2;   end
      endcase
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_x  = {{(AccW - ttf_pkg::ProdW){mul_p[ttf_pkg::ProdW-1]}}, mul_p};
  assign mul_r  = acc_q - mul_x;
  assign flip   = det_q[AccW-1];
  assign vec_en = vec_q ? cfg_b_q : cfg_t_q;
  assign m_or   = m_q[0] | m_q[1] | m_q[2];
  assign sq_t   = sr_q + sb_q;
  assign div_t  = {rem_q, num_q[NumW-1]};
  assign qv     = quo_q[OutW-1:0];

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == ttf_pkg::ST_DONE) && (!ov_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttf_pkg::ST_IDLE:  if (in_acc && phase_q == ttf_pkg::PH_V2) state_d = ttf_pkg::ST_MUL;
      ttf_pkg::ST_MUL:   if (step_q == ttf_pkg::MulLast) state_d = ttf_pkg::ST_VSEL;
      ttf_pkg::ST_VSEL:  state_d = (vec_en && det_q != '0) ? ttf_pkg::ST_SHIFT
                                                          : ttf_pkg::ST_VNEXT;
      ttf_pkg::ST_SHIFT: begin
        if (m_or == '0) state_d = ttf_pkg::ST_VNEXT;
        else if (m_or[AccW-1:ttf_pkg::NormBits] == '0 && m_or[ttf_pkg::NormBits-1])
          state_d = ttf_pkg::ST_SQ;
      end
      ttf_pkg::ST_SQ:    if (step_q == ttf_pkg::SqLast) state_d = ttf_pkg::ST_SQRT;
      ttf_pkg::ST_SQRT:  if (sb_q[0]) state_d = ttf_pkg::ST_DIVLD;
      ttf_pkg::ST_DIVLD: state_d = ttf_pkg::ST_DIV;
      ttf_pkg::ST_DIV:   if (cnt_q == CntW'(1)) state_d = ttf_pkg::ST_DIVST;
      ttf_pkg::ST_DIVST: state_d = (comp_q == 2'd2) ? ttf_pkg::ST_VNEXT : ttf_pkg::ST_DIVLD;
      ttf_pkg::ST_VNEXT: state_d = vec_q ? ttf_pkg::ST_DONE : ttf_pkg::ST_VSEL;
      ttf_pkg::ST_DONE:  if (out_load) state_d = ttf_pkg::ST_IDLE;
      default:           state_d = ttf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready        = (state_q == ttf_pkg::ST_IDLE);
    out_o.valid       = ov_q;
    out_o.tangent_x   = ores_q[0][0];
    out_o.tangent_y   = ores_q[0][1];
    out_o.tangent_z   = ores_q[0][2];
    out_o.bitangent_x = ores_q[1][0];
    out_o.bitangent_y = ores_q[1][1];
    out_o.bitangent_z = ores_q[1][2];
    out_o.tangent_valid   = otv_q;
    out_o.bitangent_valid = obv_q;
    out_o.degenerate      = odg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttf_pkg::ST_IDLE;
      phase_q <= ttf_pkg::PH_V0;
      cfg_t_q <= 1'b1;
      cfg_b_q <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ttf_pkg::CfgIdxTangent) cfg_t_q <= cfg_data_i;
        if (cfg_idx_i == ttf_pkg::CfgIdxBitangent) cfg_b_q <= cfg_data_i;
      end
      if (in_acc) begin
        unique case (phase_q)
          ttf_pkg::PH_V0: phase_q <= ttf_pkg::PH_V1;
          ttf_pkg::PH_V1: phase_q <= ttf_pkg::PH_V2;
          default:        phase_q <= ttf_pkg::PH_V0;
        endcase
      end
      if (out_load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ttf_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (phase_q)
            ttf_pkg::PH_V0: begin
              hp0_q <= '{in_i.pos_x, in_i.pos_y, in_i.pos_z};
              ht0_q <= '{in_i.tex_u, in_i.tex_v};
            end
            ttf_pkg::PH_V1: begin
              hp1_q <= '{in_i.pos_x, in_i.pos_y, in_i.pos_z};
              ht1_q <= '{in_i.tex_u, in_i.tex_v};
            end
            default: begin
              p2_q  <= '{in_i.pos_x, in_i.pos_y, in_i.pos_z};
              t2_q  <= '{in_i.tex_u, in_i.tex_v};
            end
          endcase
        end
        step_q  <= '0;
        vec_q   <= 1'b0;
        degen_q <= 1'b0;
        res_q   <= '{default: '0};
      end
      ttf_pkg::ST_MUL: begin
        step_q <= step_q + 1'b1;
        if (!step_q[0]) acc_q <= mul_x;
        else begin
          unique case (step_q)
            4'd1:    det_q    <= mul_r;
            4'd3:    tn_q[0]  <= mul_r;
            4'd5:    tn_q[1]  <= mul_r;
            4'd7:    tn_q[2]  <= mul_r;
            4'd9:    bn_q[0]  <= mul_r;
            4'd11:   bn_q[1]  <= mul_r;
            default: bn_q[2]  <= mul_r;
          endcase
        end
      end
      ttf_pkg::ST_VSEL: begin
        if (vec_en && det_q == '0) degen_q <= 1'b1;
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= vec_q ? bn_q[k][AccW-1] : tn_q[k][AccW-1];
          m_q[k]   <= vec_q ? (bn_q[k][AccW-1] ? -bn_q[k] : bn_q[k])
                            : (tn_q[k][AccW-1] ? -tn_q[k] : tn_q[k]);
        end
        step_q <= '0;
        ss_q   <= '0;
      end
      ttf_pkg::ST_SHIFT: begin
        if (m_or == '0) degen_q <= 1'b1;
        else if (m_or[AccW-1:ttf_pkg::NormBits] != '0) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
        end else if (!m_or[ttf_pkg::NormBits-1]) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
        end
      end
      ttf_pkg::ST_SQ: begin
        step_q <= step_q + 1'b1;
        ss_q   <= ss_q + mul_p[ttf_pkg::SsW-1:0];
        sx_q   <= ss_q + mul_p[ttf_pkg::SsW-1:0];
        sr_q   <= '0;
        sb_q   <= ttf_pkg::SsW'(1) << (ttf_pkg::SsW - 2);
      end
      ttf_pkg::ST_SQRT: begin
        if (sx_q >= sq_t) begin
          sx_q <= sx_q - sq_t;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q   <= sb_q >> 2;
        comp_q <= 2'd0;
      end
      ttf_pkg::ST_DIVLD: begin
        num_q <= ({m_q[comp_q][NumW-OUT_FRAC_BITS-1:0], {OUT_FRAC_BITS{1'b0}}})
               + NumW'(sr_q[ttf_pkg::LenW-1:1]);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CntW'(NumW);
      end
      ttf_pkg::ST_DIV: begin
        num_q <= num_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (div_t >= {1'b0, sr_q[ttf_pkg::LenW-1:0]}) begin
          rem_q <= ttf_pkg::LenW'(div_t - {1'b0, sr_q[ttf_pkg::LenW-1:0]});
          quo_q <= {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_q <= div_t[ttf_pkg::LenW-1:0];
          quo_q <= {quo_q[NumW-2:0], 1'b0};
        end
      end
      ttf_pkg::ST_DIVST: begin
        res_q[vec_q][comp_q] <= (neg_q[comp_q] ^ flip) ? -$signed(qv) : $signed(qv);
        comp_q <= comp_q + 1'b1;
      end
      ttf_pkg::ST_VNEXT: vec_q <= 1'b1;
      ttf_pkg::ST_DONE: begin
        if (out_load) begin
          ores_q <= res_q;
          otv_q  <= cfg_t_q;
          obv_q  <= cfg_b_q;
          odg_q  <= degen_q;
        end
      end
      default: ;
    endcase
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("vertex phase out of range");
  a_tan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !otv_q |-> ores_q[0][0] == '0 && ores_q[0][1] == '0 && ores_q[0][2] == '0)
    else $error("disabled tangent not zero");
  a_degen_needs_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && odg_q |-> otv_q || obv_q) else $error("degenerate without enabled vector");
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == ttf_pkg::ST_DONE) else $error("beat not from done");
endmodule
`default_nettype wire
